FILE: src/bmrf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Banked mode register file package
// Request codes, mode codes, status bits and the banking map functions.
// ----------------------------------------------------------------------------
package bmrf_pkg;

  localparam int unsigned NumPhys   = 31;
  localparam int unsigned NumSaved  = 5;
  localparam int unsigned PhysAw    = 5;
  localparam int unsigned SlotAw    = 3;
  localparam int unsigned DataW     = 32;

  localparam logic [4:0] ModeUsr = 5'h10;
  localparam logic [4:0] ModeFiq = 5'h11;
  localparam logic [4:0] ModeIrq = 5'h12;
  localparam logic [4:0] ModeSvc = 5'h13;
  localparam logic [4:0] ModeAbt = 5'h17;
  localparam logic [4:0] ModeUnd = 5'h1B;
  localparam logic [4:0] ModeSys = 5'h1F;

  localparam logic [DataW-1:0] StatusReset = 32'h0000_00D3;
  localparam int unsigned      BitT        = 5;
  localparam int unsigned      BitI        = 7;
  localparam logic [DataW-1:0] AlignWord   = 32'hFFFF_FFFC;
  localparam logic [DataW-1:0] AlignHalf   = 32'hFFFF_FFFE;

  localparam logic [3:0] IdxSp = 4'd13;
  localparam logic [3:0] IdxLr = 4'd14;
  localparam logic [3:0] IdxPc = 4'd15;

  typedef enum logic [2:0] {
    REQ_READ_REG     = 3'd0,
    REQ_WRITE_REG    = 3'd1,
    REQ_READ_SAVED   = 3'd2,
    REQ_WRITE_SAVED  = 3'd3,
    REQ_WRITE_STATUS = 3'd4,
    REQ_RESTORE      = 3'd5,
    REQ_READ_STATUS  = 3'd6
  } req_e;

  typedef struct packed {
    logic              hit;
    logic [SlotAw-1:0] idx;
  } slot_t;

  // One access to the physical register memory.
  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [PhysAw-1:0] addr;
    logic [DataW-1:0]  wdata;
  } rf_access_t;

  function automatic slot_t saved_slot(input logic [4:0] mode);
    slot_t s;
    s.hit = 1'b1;
    s.idx = '0;
    unique case (mode)
      ModeFiq: s.idx = 3'd0;
      ModeSvc: s.idx = 3'd1;
      ModeAbt: s.idx = 3'd2;
      ModeIrq: s.idx = 3'd3;
      ModeUnd: s.idx = 3'd4;
      default: s.hit = 1'b0;
    endcase
    return s;
  endfunction

  function automatic logic mode_known(input logic [4:0] mode);
    slot_t s;
    s = saved_slot(mode);
    return (mode == ModeUsr) || (mode == ModeSys) || s.hit;
  endfunction

  // Physical register for a logical index in a known mode.
  function automatic logic [PhysAw-1:0] phys_index(input logic [4:0] mode,
                                                   input logic [3:0] idx);
    logic [PhysAw-1:0] base;
    logic              banked;
    base   = '0;
    banked = 1'b1;
    unique case (mode)
      ModeSvc: base = 5'd23;
      ModeAbt: base = 5'd25;
      ModeIrq: base = 5'd27;
      ModeUnd: base = 5'd29;
      default: banked = 1'b0;
    endcase
    if (mode == ModeFiq) begin
      if (idx >= 4'd8 && idx <= IdxLr) begin
        return {1'b0, idx} + 5'd8;
      end
      return {1'b0, idx};
    end
    if (banked && (idx == IdxSp || idx == IdxLr)) begin
      return base + {4'd0, (idx == IdxLr)};
    end
    return {1'b0, idx};
  endfunction

endpackage

FILE: src/bmrf_regmem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Physical register memory
// Synchronous memory with a registered read port; entries never written since
// reset read as zero through a row of valid bits.
// ----------------------------------------------------------------------------
module bmrf_regmem
  import bmrf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rf_access_t       acc_i,
  input  logic             hold_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [NumPhys];
  logic [NumPhys-1:0] valid_q;
  logic [DataW-1:0]   rdata_q;
  logic               rvalid_q;

  always_ff @(posedge clk_i) begin
    if (acc_i.wr_en) begin
      mem[acc_i.addr] <= acc_i.wdata;
    end
    if (acc_i.rd_en && !hold_i) begin
      rdata_q <= mem[acc_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (acc_i.wr_en) begin
        valid_q[acc_i.addr] <= 1'b1;
      end
      if (acc_i.rd_en && !hold_i) begin
        rvalid_q <= valid_q[acc_i.addr];
      end
    end
  end

  // The write and read of one cycle never come from the same request.
  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

FILE: src/banked_mode_register_file_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Banked mode register file core
// Processor register file with per-mode register banks and saved status words.
// ----------------------------------------------------------------------------
// Usage: requests arrive on the in_valid_i / in_ready_o channel, one
// transaction per request, and each request yields exactly one result
// transaction on out_valid_o / out_ready_i.
// All writes (registers, saved status, live status) take effect at the edge
// that accepts the request. A register read is issued to the physical
// register memory at that same edge, which registers its data in the
// memory's output register as out_valid_o is set for the result.
// Throughput is one request per cycle while the receiver keeps out_ready_i
// high: the result register frees up in the same cycle in which its
// transaction completes, and a new request is taken then.
// When the receiver stalls, the result holds and in_ready_o drops until the
// result transaction completes.
// Reset clears the result valid flag, loads the live status with supervisor
// mode and interrupts disabled, zeroes the saved status words and marks all
// physical registers as unwritten, so they read as zero.
// ----------------------------------------------------------------------------
module banked_mode_register_file_core
  import bmrf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [2:0]       req_type_i,
  input  logic             use_given_mode_i,
  input  logic [4:0]       given_mode_i,
  input  logic [3:0]       reg_index_i,
  input  logic [31:0]      write_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [31:0]      read_data_o,
  output logic [31:0]      status_now_o,
  output logic             irq_recheck_o,
  output logic             bad_mode_o
);

  // Live status and the saved status words of the five exception modes.
  logic [DataW-1:0] status_q, status_d;
  logic [DataW-1:0] saved_q [NumSaved];

  // Result register. When sel_mem_q is set the read data comes from the
  // register memory's output register, otherwise from other_q.
  logic             out_valid_q;
  logic             sel_mem_q, sel_mem_d;
  logic [DataW-1:0] other_q, other_d;
  logic             irq_q, irq_d;
  logic             bad_q, bad_d;

  logic             accept;
  req_e             req;
  logic [4:0]       cur_mode;
  logic [4:0]       acc_mode;
  slot_t            slot;
  logic             saved_wr;
  rf_access_t       acc;
  logic [DataW-1:0] mem_rdata;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign req        = req_e'(req_type_i);
  assign cur_mode   = status_q[4:0];
  assign acc_mode   = use_given_mode_i ? given_mode_i : cur_mode;
  assign slot       = saved_slot(cur_mode);

  always_comb begin
    status_d   = status_q;
    sel_mem_d  = 1'b0;
    other_d    = '0;
    irq_d      = 1'b0;
    bad_d      = 1'b0;
    saved_wr   = 1'b0;
    acc.rd_en  = 1'b0;
    acc.wr_en  = 1'b0;
    acc.addr   = phys_index(acc_mode, reg_index_i);
    acc.wdata  = write_data_i;
    // The program counter is kept aligned to the instruction size of the
    // live state, even when the access goes through a given mode.
    if (reg_index_i == IdxPc) begin
      acc.wdata = write_data_i & (status_q[BitT] ? AlignHalf : AlignWord);
    end
    unique case (req)
      REQ_READ_REG, REQ_WRITE_REG: begin
        bad_d = !mode_known(acc_mode);
        if (!bad_d) begin
          sel_mem_d = (req == REQ_READ_REG);
          acc.rd_en = accept && (req == REQ_READ_REG);
          acc.wr_en = accept && (req == REQ_WRITE_REG);
        end
      end
      REQ_READ_SAVED: begin
        bad_d   = !mode_known(cur_mode);
        // Modes without a saved status word read the live status instead.
        other_d = slot.hit ? saved_q[slot.idx] : status_q;
      end
      REQ_WRITE_SAVED: begin
        bad_d    = !mode_known(cur_mode);
        saved_wr = slot.hit;
      end
      REQ_WRITE_STATUS: begin
        bad_d    = !mode_known(cur_mode);
        status_d = write_data_i;
        irq_d    = !write_data_i[BitI];
      end
      REQ_RESTORE: begin
        bad_d = !mode_known(cur_mode);
        if (slot.hit) begin
          status_d = saved_q[slot.idx];
        end
        irq_d = !status_d[BitI];
      end
      REQ_READ_STATUS: begin
        bad_d   = !mode_known(cur_mode);
        other_d = status_q;
      end
      default: begin
        // Unused request code: no state change, empty result.
      end
    endcase
  end

  bmrf_regmem u_regmem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .acc_i   (acc),
    .hold_i  (!accept),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q    <= StatusReset;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumSaved; i++) begin
        saved_q[i] <= '0;
      end
    end else begin
      if (accept) begin
        status_q    <= status_d;
        out_valid_q <= 1'b1;
        if (saved_wr) begin
          saved_q[slot.idx] <= write_data_i;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sel_mem_q <= sel_mem_d;
      other_q   <= other_d;
      irq_q     <= irq_d;
      bad_q     <= bad_d;
    end
  end

  // The live status only changes on acceptance, so while a result is
  // pending the live status register is exactly the post-request status.
  assign out_valid_o   = out_valid_q;
  assign read_data_o   = sel_mem_q ? mem_rdata : other_q;
  assign status_now_o  = status_q;
  assign irq_recheck_o = irq_q;
  assign bad_mode_o    = bad_q;

endmodule

FILE: sim/banked_mode_register_file_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Banked mode register file core testbench
// Drives register, saved status and live status requests into the core,
// predicts every result from a private copy of the register file state and
// checks each result transaction field by field, in order.
// ----------------------------------------------------------------------------

import bmrf_pkg::*;

// Request code 7 has no member in the request enum; the core treats it as a
// no-op that still returns one result.
localparam logic [2:0] ReqNoOp = 3'd7;

typedef struct packed {
  logic [31:0] read_data;
  logic [31:0] status;
  logic        irq;
  logic        bad;
} regfile_result_t;

class bank_regfile_scoreboard;
  logic [31:0]     phys_regs [31];
  logic [31:0]     live_status;
  logic [31:0]     saved_words [5];
  regfile_result_t expected_q [$];
  int              errors;

  function new();
    foreach (phys_regs[i]) phys_regs[i] = '0;
    foreach (saved_words[i]) saved_words[i] = '0;
    live_status = StatusReset;
    errors      = 0;
  endfunction

  // Saved status slot owned by a mode, -1 when the mode has none.
  function int slot_of(logic [4:0] mode);
    case (mode)
      ModeFiq: return 0;
      ModeSvc: return 1;
      ModeAbt: return 2;
      ModeIrq: return 3;
      ModeUnd: return 4;
      default: return -1;
    endcase
  endfunction

  function bit known(logic [4:0] mode);
    return (mode == ModeUsr) || (mode == ModeSys) || (slot_of(mode) >= 0);
  endfunction

  function int phys_of(logic [4:0] mode, logic [3:0] idx);
    int bank_base;
    if (mode == ModeFiq) begin
      if (idx >= 4'd8 && idx <= IdxLr) return 16 + int'(idx) - 8;
      return int'(idx);
    end
    case (mode)
      ModeSvc: bank_base = 23;
      ModeAbt: bank_base = 25;
      ModeIrq: bank_base = 27;
      ModeUnd: bank_base = 29;
      default: return int'(idx);
    endcase
    if (idx == IdxSp || idx == IdxLr) return bank_base + int'(idx) - int'(IdxSp);
    return int'(idx);
  endfunction

  // Applies one accepted request to the private state and queues its result.
  function void note_request(logic [2:0] req, logic use_given, logic [4:0] given,
                             logic [3:0] idx, logic [31:0] data);
    regfile_result_t r;
    logic [4:0]      cur;
    logic [4:0]      mode;
    int              slot;
    cur         = live_status[4:0];
    slot        = slot_of(cur);
    r.read_data = '0;
    r.irq       = 1'b0;
    r.bad       = 1'b0;
    case (req)
      REQ_READ_REG, REQ_WRITE_REG: begin
        mode = use_given ? given : cur;
        if (!known(mode)) begin
          r.bad = 1'b1;
        end else if (req == REQ_READ_REG) begin
          r.read_data = phys_regs[phys_of(mode, idx)];
        end else begin
          if (idx == IdxPc) data &= live_status[BitT] ? AlignHalf : AlignWord;
          phys_regs[phys_of(mode, idx)] = data;
        end
      end
      ReqNoOp: begin
      end
      default: begin
        r.bad = !known(cur);
        case (req)
          REQ_READ_SAVED: begin
            if (slot >= 0) r.read_data = saved_words[slot];
            else r.read_data = live_status;
          end
          REQ_WRITE_SAVED: begin
            if (slot >= 0) saved_words[slot] = data;
          end
          REQ_WRITE_STATUS: begin
            live_status = data;
            r.irq       = !live_status[BitI];
          end
          REQ_RESTORE: begin
            if (slot >= 0) live_status = saved_words[slot];
            r.irq = !live_status[BitI];
          end
          default: r.read_data = live_status;
        endcase
      end
    endcase
    r.status = live_status;
    expected_q.push_back(r);
  endfunction

  task report(string msg);
    $display("%0t ERROR: %s", $time, msg);
    errors++;
  endtask

  task check_result(logic [31:0] rd, logic [31:0] st, logic irq, logic bad);
    regfile_result_t e;
    if (expected_q.size() == 0) begin
      report($sformatf("result with no request pending: read_data=%h status=%h", rd, st));
      return;
    end
    e = expected_q.pop_front();
    if (rd !== e.read_data)
      report($sformatf("read_data got %h expected %h", rd, e.read_data));
    if (st !== e.status)
      report($sformatf("status_now got %h expected %h", st, e.status));
    if (irq !== e.irq)
      report($sformatf("irq_recheck got %b expected %b", irq, e.irq));
    if (bad !== e.bad)
      report($sformatf("bad_mode got %b expected %b", bad, e.bad));
  endtask
endclass

module banked_mode_register_file_core_tb;

  // This bound only catches a hung handshake; a normal run ends well before it.
  localparam int CycleLimit = 300000;
  // Length of the forced receiver stall that backs the core up.
  localparam int LongHold   = 80;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [2:0]  req_type_i;
  logic        use_given_mode_i;
  logic [4:0]  given_mode_i;
  logic [3:0]  reg_index_i;
  logic [31:0] write_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] read_data_o;
  logic [31:0] status_now_o;
  logic        irq_recheck_o;
  logic        bad_mode_o;

  // Idle rates in percent for the current phase, and the request counter that
  // asks the receiver for one long stall.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int long_hold_req  = 0;
  int cycles         = 0;

  bank_regfile_scoreboard sb;

  banked_mode_register_file_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .use_given_mode_i(use_given_mode_i),
    .given_mode_i    (given_mode_i),
    .reg_index_i     (reg_index_i),
    .write_data_i    (write_data_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .read_data_o     (read_data_o),
    .status_now_o    (status_now_o),
    .irq_recheck_o   (irq_recheck_o),
    .bad_mode_o      (bad_mode_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: if the run has not finished by the limit, something is stuck.
  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("banked_mode_register_file_core_tb: FAIL");
    $finish;
  end

  // Receiver. It stalls at random at the phase rate, and on request holds
  // ready low for a long stretch that it counts down itself. During that
  // stretch the sender keeps offering requests, so the result register fills
  // and the core has to drop in_ready_o.
  initial begin
    int hold_left;
    int holds_served;
    hold_left    = 0;
    holds_served = 0;
    out_ready_i  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!rst_ni) begin
        out_ready_i <= 1'b0;
      end else begin
        if (long_hold_req > holds_served) begin
          holds_served++;
          hold_left = LongHold;
        end
        if (hold_left > 0) begin
          hold_left--;
          out_ready_i <= 1'b0;
        end else begin
          out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
        end
      end
    end
  end

  // Monitor. Both channels are sampled at the rising edge, where the values
  // seen are the ones the core acts on at that edge. A request accepted at
  // this edge can only produce its result at a later edge, so noting it
  // before the result check keeps the expectation queue in order.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        sb.note_request(req_type_i, use_given_mode_i, given_mode_i, reg_index_i,
                        write_data_i);
      if (out_valid_o && out_ready_i)
        sb.check_result(read_data_o, status_now_o, irq_recheck_o, bad_mode_o);
    end
  end

  // Offers one request transaction. Called and returning at a falling edge;
  // valid is raised without looking at ready and held with the payload
  // steady until the core takes it.
  task automatic send_request(input logic [2:0] req, input logic use_given,
                              input logic [4:0] given, input logic [3:0] idx,
                              input logic [31:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    req_type_i       <= req;
    use_given_mode_i <= use_given;
    given_mode_i     <= given;
    reg_index_i      <= idx;
    write_data_i     <= data;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Mostly one of the seven defined modes, sometimes any five-bit code so
  // that the unknown-mode handling is exercised too.
  function automatic logic [4:0] pick_mode();
    if ($urandom_range(99) >= 85) return 5'($urandom_range(31));
    case ($urandom_range(6))
      0:       return ModeUsr;
      1:       return ModeFiq;
      2:       return ModeIrq;
      3:       return ModeSvc;
      4:       return ModeAbt;
      5:       return ModeUnd;
      default: return ModeSys;
    endcase
  endfunction

  // A status word with random flag bits and a mostly valid mode field.
  function automatic logic [31:0] status_word();
    logic [31:0] w;
    w      = $urandom;
    w[4:0] = pick_mode();
    return w;
  endfunction

  // One random request. Status writes mostly carry sensible mode codes so
  // that the core keeps moving between banks rather than sitting in an
  // unknown mode; register traffic is spread over both addressing styles.
  task automatic random_request();
    int          pick;
    logic [2:0]  req;
    logic [31:0] data;
    pick = $urandom_range(99);
    if (pick < 24)      req = REQ_READ_REG;
    else if (pick < 48) req = REQ_WRITE_REG;
    else if (pick < 56) req = REQ_READ_SAVED;
    else if (pick < 66) req = REQ_WRITE_SAVED;
    else if (pick < 78) req = REQ_WRITE_STATUS;
    else if (pick < 87) req = REQ_RESTORE;
    else if (pick < 97) req = REQ_READ_STATUS;
    else                req = ReqNoOp;
    if (req == REQ_WRITE_SAVED || req == REQ_WRITE_STATUS) begin
      data = ($urandom_range(99) < 85) ? status_word() : 32'($urandom);
    end else begin
      pick = $urandom_range(9);
      data = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : 32'($urandom);
    end
    send_request(req, ($urandom_range(99) < 40), pick_mode(), 4'($urandom_range(15)),
                 data);
  endtask

  initial begin
    sb               = new();
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    req_type_i       = REQ_READ_REG;
    use_given_mode_i = 1'b0;
    given_mode_i     = '0;
    reg_index_i      = '0;
    write_data_i     = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, run under the first idle pattern. The core starts in
    // supervisor mode with interrupts disabled.
    send_idle_pct  = 9;
    recv_stall_pct = 76;
    send_request(REQ_READ_STATUS, 1'b0, 5'h00, 4'd0, 32'h0);
    send_request(REQ_READ_SAVED, 1'b0, 5'h00, 4'd0, 32'h0);
    send_request(REQ_WRITE_REG, 1'b0, 5'h00, 4'd0, 32'hFFFF_FFFF);
    send_request(REQ_WRITE_REG, 1'b0, 5'h00, IdxSp, 32'hA5A5_5A5A);
    // Program counter write with the T bit clear keeps a word address.
    send_request(REQ_WRITE_REG, 1'b0, 5'h00, IdxPc, 32'hFFFF_FFFF);
    send_request(REQ_READ_REG, 1'b0, 5'h00, IdxPc, 32'h0);
    // Fast interrupt banks 8 to 14; user mode must not see those copies.
    send_request(REQ_WRITE_REG, 1'b1, ModeFiq, 4'd8, 32'h1234_5678);
    send_request(REQ_WRITE_REG, 1'b1, ModeFiq, IdxLr, 32'hFFFF_FFFF);
    send_request(REQ_READ_REG, 1'b1, ModeUsr, 4'd8, 32'h0);
    send_request(REQ_READ_REG, 1'b1, ModeFiq, 4'd8, 32'h0);
    // Unknown access modes: the write is dropped and the read gives zero.
    send_request(REQ_WRITE_REG, 1'b1, 5'h00, 4'd3, 32'hFFFF_FFFF);
    send_request(REQ_READ_REG, 1'b1, 5'h1E, 4'd3, 32'h0);
    send_request(REQ_WRITE_SAVED, 1'b0, 5'h00, 4'd0, 32'h0000_00D1);
    send_request(REQ_READ_SAVED, 1'b0, 5'h00, 4'd0, 32'h0);
    // User mode with the T bit set and interrupts enabled.
    send_request(REQ_WRITE_STATUS, 1'b0, 5'h00, 4'd0, 32'h0000_0030);
    // Program counter write in a given mode still follows the live T bit.
    send_request(REQ_WRITE_REG, 1'b1, ModeSvc, IdxPc, 32'hFFFF_FFFF);
    send_request(REQ_READ_REG, 1'b1, ModeSvc, IdxPc, 32'h0);
    // User mode has no saved status: reads give the live word, writes and
    // restores change nothing, and the restore still reports the I bit.
    send_request(REQ_READ_SAVED, 1'b0, 5'h00, 4'd0, 32'h0);
    send_request(REQ_WRITE_SAVED, 1'b0, 5'h00, 4'd0, 32'hDEAD_BEEF);
    send_request(REQ_RESTORE, 1'b0, 5'h00, 4'd0, 32'h0);
    // An unknown live mode code flags all but the no-op below.
    send_request(REQ_WRITE_STATUS, 1'b0, 5'h00, 4'd0, 32'h8000_0000);
    send_request(REQ_RESTORE, 1'b0, 5'h00, 4'd0, 32'h0);
    send_request(REQ_READ_REG, 1'b0, 5'h00, IdxSp, 32'h0);
    send_request(ReqNoOp, 1'b0, 5'h00, 4'd0, 32'h0);
    // Back to supervisor, then restore the fast interrupt status saved above.
    send_request(REQ_WRITE_STATUS, 1'b0, 5'h00, 4'd0, 32'h0000_00D3);
    send_request(REQ_RESTORE, 1'b0, 5'h00, 4'd0, 32'h0);

    // Random part: slow receiver, then slow sender.
    repeat (370) random_request();
    send_idle_pct  = 76;
    recv_stall_pct = 9;
    repeat (370) random_request();

    // Back-pressure burst: the receiver holds off while requests keep coming.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    long_hold_req++;
    repeat (40) random_request();

    // Full rate on both sides.
    repeat (320) random_request();
    in_valid_i <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("banked_mode_register_file_core_tb: PASS");
    end else begin
      $display("banked_mode_register_file_core_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: banked_mode_register_file_core.f
src/bmrf_pkg.sv
src/bmrf_regmem.sv
src/banked_mode_register_file_core.sv
sim/banked_mode_register_file_core_tb.sv
